FILE: sv/aeh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aeh_pkg: shared types and constants of the encoder heading unit
// Widths of the counters, the heading range and the register map.
// ----------------------------------------------------------------------------
package aeh_pkg;

	localparam int ELAPSED_W       = 16;
	localparam int HEADING_MODULUS = 360;
	localparam int HEADING_W       = $clog2(HEADING_MODULUS + 1);
	localparam int HSUM_W          = HEADING_W + 2;
	localparam int HEADING_OUT_W   = 9;
	localparam int DELTA_W         = 5;
	localparam int BAND_W          = 16;
	localparam int STEP_W          = 4;
	localparam int CMP_W           = (ELAPSED_W > BAND_W) ? ELAPSED_W : BAND_W;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 16;
	localparam int IN_TDATA_W      = 8;
	localparam int OUT_TDATA_W     = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BAND_FASTEST = 3'd0,
		REG_BAND_FAST    = 3'd1,
		REG_BAND_MEDIUM  = 3'd2,
		REG_BAND_SLOW    = 3'd3,
		REG_STEP_FASTEST = 3'd4,
		REG_STEP_FAST    = 3'd5,
		REG_STEP_MEDIUM  = 3'd6,
		REG_STEP_SLOW    = 3'd7
	} cfg_idx_t;

	localparam logic [BAND_W-1:0] BAND_FASTEST_RST = 16'd2;
	localparam logic [BAND_W-1:0] BAND_FAST_RST    = 16'd20;
	localparam logic [BAND_W-1:0] BAND_MEDIUM_RST  = 16'd50;
	localparam logic [BAND_W-1:0] BAND_SLOW_RST    = 16'd100;
	localparam logic [STEP_W-1:0] STEP_FASTEST_RST = 4'd8;
	localparam logic [STEP_W-1:0] STEP_FAST_RST    = 4'd6;
	localparam logic [STEP_W-1:0] STEP_MEDIUM_RST  = 4'd4;
	localparam logic [STEP_W-1:0] STEP_SLOW_RST    = 4'd2;
	localparam logic [STEP_W-1:0] STEP_DEFAULT     = 4'd1;

	localparam logic [HEADING_W-1:0] HEADING_RST = HEADING_W'(HEADING_MODULUS);

	typedef struct packed {
		logic [BAND_W-1:0] band_fastest;
		logic [BAND_W-1:0] band_fast;
		logic [BAND_W-1:0] band_medium;
		logic [BAND_W-1:0] band_slow;
		logic [STEP_W-1:0] step_fastest;
		logic [STEP_W-1:0] step_fast;
		logic [STEP_W-1:0] step_medium;
		logic [STEP_W-1:0] step_slow;
	} cfg_t;

	typedef struct packed {
		logic                 primed;
		logic                 last_clk;
		logic [ELAPSED_W-1:0] elapsed;
		logic [HEADING_W-1:0] heading;
	} enc_state_t;

	typedef struct packed {
		logic [HEADING_OUT_W-1:0] heading;
		logic [DELTA_W-1:0]       step_delta;
		logic                     moved;
	} result_t;

endpackage

FILE: sv/aeh_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aeh_cfg_regs: configuration register file
// Band limits and step sizes, written through a plain write port.
// ----------------------------------------------------------------------------
module aeh_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [aeh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [aeh_pkg::CFG_DATA_W-1:0] cfg_data,
	output aeh_pkg::cfg_t                  cfg
);

	aeh_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.band_fastest <= aeh_pkg::BAND_FASTEST_RST;
			cfg_q.band_fast    <= aeh_pkg::BAND_FAST_RST;
			cfg_q.band_medium  <= aeh_pkg::BAND_MEDIUM_RST;
			cfg_q.band_slow    <= aeh_pkg::BAND_SLOW_RST;
			cfg_q.step_fastest <= aeh_pkg::STEP_FASTEST_RST;
			cfg_q.step_fast    <= aeh_pkg::STEP_FAST_RST;
			cfg_q.step_medium  <= aeh_pkg::STEP_MEDIUM_RST;
			cfg_q.step_slow    <= aeh_pkg::STEP_SLOW_RST;
		end else if (cfg_we) begin
			unique case (aeh_pkg::cfg_idx_t'(cfg_index))
				aeh_pkg::REG_BAND_FASTEST: cfg_q.band_fastest <= cfg_data[aeh_pkg::BAND_W-1:0];
				aeh_pkg::REG_BAND_FAST:    cfg_q.band_fast    <= cfg_data[aeh_pkg::BAND_W-1:0];
				aeh_pkg::REG_BAND_MEDIUM:  cfg_q.band_medium  <= cfg_data[aeh_pkg::BAND_W-1:0];
				aeh_pkg::REG_BAND_SLOW:    cfg_q.band_slow    <= cfg_data[aeh_pkg::BAND_W-1:0];
				aeh_pkg::REG_STEP_FASTEST: cfg_q.step_fastest <= cfg_data[aeh_pkg::STEP_W-1:0];
				aeh_pkg::REG_STEP_FAST:    cfg_q.step_fast    <= cfg_data[aeh_pkg::STEP_W-1:0];
				aeh_pkg::REG_STEP_MEDIUM:  cfg_q.step_medium  <= cfg_data[aeh_pkg::STEP_W-1:0];
				aeh_pkg::REG_STEP_SLOW:    cfg_q.step_slow    <= cfg_data[aeh_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: sv/aeh_step_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aeh_step_calc: per-sample detent and heading logic
// Edge detect, elapsed-time band lookup, signed step and heading wrap.
// ----------------------------------------------------------------------------
module aeh_step_calc (
	input  aeh_pkg::cfg_t       cfg,
	input  aeh_pkg::enc_state_t cur,
	input  logic                clk_level,
	input  logic                data_level,
	input  logic                ms_tick,
	output aeh_pkg::enc_state_t nxt,
	output aeh_pkg::result_t    res
);

	localparam logic signed [aeh_pkg::HSUM_W-1:0] MOD_S  = aeh_pkg::HSUM_W'(aeh_pkg::HEADING_MODULUS);
	localparam logic signed [aeh_pkg::HSUM_W-1:0] ONE_S  = aeh_pkg::HSUM_W'(1);

	logic [aeh_pkg::ELAPSED_W-1:0]      t;
	logic [aeh_pkg::CMP_W-1:0]          t_cmp;
	logic [aeh_pkg::STEP_W-1:0]         step;
	logic signed [aeh_pkg::DELTA_W-1:0] delta;
	logic signed [aeh_pkg::HSUM_W-1:0]  h_sum;
	logic [aeh_pkg::HEADING_W-1:0]      h_wrap;
	logic                               detent;

	// saturating millisecond count, including this sample's tick
	assign t = cur.elapsed + aeh_pkg::ELAPSED_W'(ms_tick && (cur.elapsed != '1));
	assign t_cmp = aeh_pkg::CMP_W'(t);

	always_comb begin
		priority if (t_cmp < aeh_pkg::CMP_W'(cfg.band_fastest)) step = cfg.step_fastest;
		else if (t_cmp < aeh_pkg::CMP_W'(cfg.band_fast))        step = cfg.step_fast;
		else if (t_cmp < aeh_pkg::CMP_W'(cfg.band_medium))      step = cfg.step_medium;
		else if (t_cmp < aeh_pkg::CMP_W'(cfg.band_slow))        step = cfg.step_slow;
		else                                                    step = aeh_pkg::STEP_DEFAULT;
	end

	assign detent = cur.primed && (clk_level != cur.last_clk);

	always_comb begin
		delta = '0;
		if (detent) begin
			if (data_level != clk_level) begin
				delta = -$signed({1'b0, step});
			end else begin
				delta = $signed({1'b0, step});
			end
		end
	end

	assign h_sum = $signed({2'b00, cur.heading}) + aeh_pkg::HSUM_W'(delta);

	always_comb begin
		priority if (h_sum > MOD_S) h_wrap = aeh_pkg::HEADING_W'(h_sum - MOD_S);
		else if (h_sum < ONE_S)     h_wrap = aeh_pkg::HEADING_W'(h_sum + MOD_S);
		else                        h_wrap = aeh_pkg::HEADING_W'(h_sum);
	end

	always_comb begin
		nxt        = cur;
		nxt.primed = 1'b1;
		if (!cur.primed) begin
			// first sample: capture the clock level only
			nxt.last_clk = clk_level;
			nxt.elapsed  = '0;
		end else if (detent) begin
			nxt.last_clk = clk_level;
			nxt.elapsed  = '0;
			nxt.heading  = h_wrap;
		end else begin
			nxt.elapsed  = t;
		end
	end

	assign res.heading    = aeh_pkg::HEADING_OUT_W'(nxt.heading);
	assign res.step_delta = delta;
	assign res.moved      = detent;

endmodule

FILE: sv/accelerated_encoder_heading_unit.sv
`timescale 1ns / 1ps
// Path: an input transaction passes the input register, then the result register, before its output transaction.
// Throughput: one sample per cycle while s2 is free; the state update is combinational from the input register.
// Reset: arst_n clears valids, encoder state (heading 360, not primed) and loads register defaults.
// The sides are not fully parted: while a result waits, a new sample enters only an empty input register.
// ----------------------------------------------------------------------------
// accelerated_encoder_heading_unit: rotary encoder heading with speed-dependent step
// Samples the encoder pins, detects detents and keeps a wrapped heading.
// ----------------------------------------------------------------------------
module accelerated_encoder_heading_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// sample stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [aeh_pkg::IN_TDATA_W-1:0]  s_tdata,   // [0] clk_level, [1] data_level, [2] ms_tick
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [aeh_pkg::OUT_TDATA_W-1:0] m_tdata,   // [8:0] heading, [13:9] step_delta, [14] moved
	// configuration write port
	input  logic                            cfg_we,
	input  logic [aeh_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [aeh_pkg::CFG_DATA_W-1:0]  cfg_data
);

	aeh_pkg::cfg_t       cfg;
	aeh_pkg::enc_state_t state_q;
	aeh_pkg::enc_state_t state_nxt;
	aeh_pkg::result_t    res_calc;
	aeh_pkg::result_t    res_s2;

	logic valid_s1;
	logic clk_level_s1;
	logic data_level_s1;
	logic ms_tick_s1;
	logic valid_s2;
	logic adv_s1;
	logic s2_free;

	aeh_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Result register is free when empty or being drained this cycle.
	assign s2_free  = !valid_s2 || m_tready;
	// The sample in the input register advances (and commits its state update) when s2 is free.
	assign adv_s1   = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || s2_free;

	// Input register: hold the sample until it moves into the result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			clk_level_s1  <= s_tdata[0];
			data_level_s1 <= s_tdata[1];
			ms_tick_s1    <= s_tdata[2];
		end
	end

	aeh_step_calc u_calc (
		.cfg        (cfg),
		.cur        (state_q),
		.clk_level  (clk_level_s1),
		.data_level (data_level_s1),
		.ms_tick    (ms_tick_s1),
		.nxt        (state_nxt),
		.res        (res_calc)
	);

	// Encoder state: advance only when the sample commits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.primed   <= 1'b0;
			state_q.last_clk <= 1'b0;
			state_q.elapsed  <= '0;
			state_q.heading  <= aeh_pkg::HEADING_RST;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_calc;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, res_s2.moved, res_s2.step_delta, res_s2.heading};

`ifndef SYNTHESIS
	// heading always stays inside 1..modulus
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.heading != '0) && (state_q.heading <= aeh_pkg::HEADING_RST))
		else $error("heading out of range");

	// a result without a detent carries no step
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res_s2.moved) |-> (res_s2.step_delta == '0))
		else $error("step without detent");

	// a committed detent clears the elapsed count
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && res_calc.moved) |=> (state_q.elapsed == '0))
		else $error("elapsed not cleared on detent");

	// once primed, the unit stays primed until reset
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.primed |=> state_q.primed)
		else $error("primed flag dropped");
`endif

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the encoder heading unit
// Streams encoder pin samples into the unit, predicts heading, step and detent
// flag for every accepted sample and checks each result in order. Register
// settings change between drained phases; both stream sides idle and stall.
// ----------------------------------------------------------------------------
module testbench;
	import aeh_pkg::*;

	// One pin sample, laid out as it travels on s_tdata (clk_level lowest).
	typedef struct packed {
		logic ms_tick;
		logic data_level;
		logic clk_level;
	} pin_sample_t;

	localparam int HOLD_CYCLES = 300;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// Stimulus and expectation stores.
	pin_sample_t sample_q[$];
	result_t     heading_exp_q[$];

	// Predictor copy of the unit: registers and encoder state.
	cfg_t                 cfg_mirror;
	logic                 enc_primed;
	logic                 enc_last_clk;
	logic [ELAPSED_W-1:0] enc_elapsed;
	int                   enc_heading;

	// Flow control knobs set by the sequence.
	int   send_idle_pct;
	int   recv_idle_pct;
	bit   hold_go;
	bit   rx_hold;
	bit   sample_taken;
	logic gen_clk;

	int      n_fail;
	int      n_samples;
	int      n_results;
	int      n_settings;
	result_t want_res;

	accelerated_encoder_heading_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),    // [0] clk_level, [1] data_level, [2] ms_tick
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),    // [8:0] heading, [13:9] step_delta, [14] moved
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 4 ns clock.
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Predictor: advance the mirrored encoder state by one accepted sample and
	// return the result the unit must produce for it.
	// ------------------------------------------------------------------------
	function automatic result_t predict_heading(pin_sample_t smp);
		result_t              res;
		logic [ELAPSED_W-1:0] t;
		int                   step;
		int                   h;
		res.heading    = '0;
		res.step_delta = '0;
		res.moved      = 1'b0;
		if (!enc_primed) begin
			// First sample after reset: capture the clock level only, drop the tick.
			enc_primed   = 1'b1;
			enc_last_clk = smp.clk_level;
			enc_elapsed  = '0;
		end else begin
			t = enc_elapsed;
			// Saturate the elapsed counter at its top value.
			if (smp.ms_tick && t != '1)
				t = t + 1'b1;
			if (smp.clk_level != enc_last_clk) begin
				if (t < cfg_mirror.band_fastest)
					step = int'(cfg_mirror.step_fastest);
				else if (t < cfg_mirror.band_fast)
					step = int'(cfg_mirror.step_fast);
				else if (t < cfg_mirror.band_medium)
					step = int'(cfg_mirror.step_medium);
				else if (t < cfg_mirror.band_slow)
					step = int'(cfg_mirror.step_slow);
				else
					step = int'(STEP_DEFAULT);
				// Data differing from clock turns the other way.
				if (smp.data_level != smp.clk_level)
					step = -step;
				h = enc_heading + step;
				if (h > HEADING_MODULUS)
					h = h - HEADING_MODULUS;
				else if (h < 1)
					h = h + HEADING_MODULUS;
				enc_heading    = h;
				enc_last_clk   = smp.clk_level;
				enc_elapsed    = '0;
				res.moved      = 1'b1;
				res.step_delta = step[DELTA_W-1:0];
			end else begin
				enc_elapsed = t;
			end
		end
		res.heading = enc_heading[HEADING_OUT_W-1:0];
		return res;
	endfunction

	// Longest dwell worth generating under the current band limits.
	function automatic int dwell_cap();
		int top;
		top = int'(cfg_mirror.band_fastest);
		if (int'(cfg_mirror.band_fast) > top)
			top = int'(cfg_mirror.band_fast);
		if (int'(cfg_mirror.band_medium) > top)
			top = int'(cfg_mirror.band_medium);
		if (int'(cfg_mirror.band_slow) > top)
			top = int'(cfg_mirror.band_slow);
		if (top > 200)
			top = 200;
		return top + 10;
	endfunction

	task automatic note_failure(string msg);
		n_fail++;
		if (n_fail <= 10)
			$display("%0t ns: %s", $realtime, msg);
	endtask

	// ------------------------------------------------------------------------
	// Monitor: sample both handshakes at the rising edge. Predict on every
	// input transaction, check every output transaction against the oldest
	// expectation.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				heading_exp_q.push_back(predict_heading(pin_sample_t'(s_tdata[2:0])));
				sample_taken = 1'b1;
				n_samples++;
			end
			if (m_tvalid && m_tready) begin
				n_results++;
				if (heading_exp_q.size() == 0) begin
					note_failure($sformatf("result with nothing expected: heading %0d delta %0d moved %0b",
						m_tdata[8:0], $signed(m_tdata[13:9]), m_tdata[14]));
				end else begin
					want_res = heading_exp_q.pop_front();
					if (m_tdata[8:0] !== want_res.heading || m_tdata[13:9] !== want_res.step_delta ||
							m_tdata[14] !== want_res.moved) begin
						note_failure($sformatf(
							"mismatch: expected heading %0d delta %0d moved %0b, got heading %0d delta %0d moved %0b",
							want_res.heading, $signed(want_res.step_delta), want_res.moved,
							m_tdata[8:0], $signed(m_tdata[13:9]), m_tdata[14]));
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Driver: at the falling edge, hold the offered sample until it is taken,
	// then offer the next pending one or idle.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || sample_taken) begin
				if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tdata  <= {{(IN_TDATA_W-3){1'b0}}, sample_q.pop_front()};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			sample_taken = 1'b0;
		end
	end

	// Receiver: random back-pressure, forced low during the long hold-off.
	always @(negedge clk) begin
		if (arst_n)
			m_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
	end

	// Long receiver hold-off, counted here while the sender keeps offering.
	initial begin
		rx_hold = 1'b0;
		wait (hold_go);
		@(posedge clk);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold = 1'b0;
	end

	// Watchdog.
	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Sequence helpers
	// ------------------------------------------------------------------------
	task automatic push_sample(logic clk_level, logic data_level, logic ms_tick);
		pin_sample_t smp;
		smp.clk_level  = clk_level;
		smp.data_level = data_level;
		smp.ms_tick    = ms_tick;
		gen_clk        = clk_level;
		sample_q.push_back(smp);
	endtask

	// One detent in the given direction (1 = data follows clock).
	task automatic push_detent(logic dir, logic ms_tick);
		push_sample(~gen_clk, dir ? ~gen_clk : gen_clk, ms_tick);
	endtask

	// Stay on the current clock level for a number of ticking samples.
	task automatic push_dwell(int ticks);
		repeat (ticks) push_sample(gen_clk, 1'($urandom_range(1)), 1'b1);
	endtask

	// Wait until everything sent has come back, then let the pipeline settle.
	task automatic wait_drained();
		@(negedge clk);
		while (sample_q.size() != 0 || s_tvalid || heading_exp_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we    = 1'b0;
		case (idx)
			REG_BAND_FASTEST: cfg_mirror.band_fastest = val;
			REG_BAND_FAST:    cfg_mirror.band_fast    = val;
			REG_BAND_MEDIUM:  cfg_mirror.band_medium  = val;
			REG_BAND_SLOW:    cfg_mirror.band_slow    = val;
			REG_STEP_FASTEST: cfg_mirror.step_fastest = val[STEP_W-1:0];
			REG_STEP_FAST:    cfg_mirror.step_fast    = val[STEP_W-1:0];
			REG_STEP_MEDIUM:  cfg_mirror.step_medium  = val[STEP_W-1:0];
			REG_STEP_SLOW:    cfg_mirror.step_slow    = val[STEP_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_setting(logic [CFG_DATA_W-1:0] b0, logic [CFG_DATA_W-1:0] b1,
			logic [CFG_DATA_W-1:0] b2, logic [CFG_DATA_W-1:0] b3,
			logic [CFG_DATA_W-1:0] s0, logic [CFG_DATA_W-1:0] s1,
			logic [CFG_DATA_W-1:0] s2, logic [CFG_DATA_W-1:0] s3);
		write_reg(REG_BAND_FASTEST, b0);
		write_reg(REG_BAND_FAST, b1);
		write_reg(REG_BAND_MEDIUM, b2);
		write_reg(REG_BAND_SLOW, b3);
		write_reg(REG_STEP_FASTEST, s0);
		write_reg(REG_STEP_FAST, s1);
		write_reg(REG_STEP_MEDIUM, s2);
		write_reg(REG_STEP_SLOW, s3);
		n_settings++;
	endtask

	// Mostly well-formed turning: bursts of detents in one direction with
	// dwells that land in every band; the rest is random pin noise.
	task automatic gen_motion(int n);
		int   start;
		int   burst;
		int   dwell;
		int   cap;
		logic dir;
		start = sample_q.size();
		cap   = dwell_cap();
		while (sample_q.size() - start < n) begin
			if ($urandom_range(99) < 80) begin
				dir   = 1'($urandom_range(1));
				burst = $urandom_range(1, 8);
				repeat (burst) begin
					case ($urandom_range(9))
						0, 1, 2, 3, 4: dwell = $urandom_range(0, 3);
						5, 6, 7:       dwell = $urandom_range(0, cap / 4);
						default:       dwell = $urandom_range(0, cap);
					endcase
					repeat (dwell)
						push_sample(gen_clk, 1'($urandom_range(1)), $urandom_range(9) != 0);
					push_detent(dir, 1'($urandom_range(1)));
				end
			end else begin
				repeat ($urandom_range(1, 6))
					push_sample(1'($urandom_range(1)), 1'($urandom_range(1)),
						1'($urandom_range(1)));
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		m_tready      = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		send_idle_pct = 20;
		recv_idle_pct = 46;
		hold_go       = 1'b0;
		sample_taken  = 1'b0;
		gen_clk       = 1'b0;
		n_fail        = 0;
		n_samples     = 0;
		n_results     = 0;
		n_settings    = 0;
		cfg_mirror    = '{BAND_FASTEST_RST, BAND_FAST_RST, BAND_MEDIUM_RST, BAND_SLOW_RST,
			STEP_FASTEST_RST, STEP_FAST_RST, STEP_MEDIUM_RST, STEP_SLOW_RST};
		enc_primed    = 1'b0;
		enc_last_clk  = 1'b0;
		enc_elapsed   = '0;
		enc_heading   = HEADING_MODULUS;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, reset defaults: priming sample with a tick that must be
		// dropped, wrap upward past 360 and downward below 1, second band.
		push_sample(1'b1, 1'b0, 1'b1);
		push_detent(1'b1, 1'b0);
		push_detent(1'b0, 1'b1);
		push_sample(gen_clk, 1'b1, 1'b0);
		push_dwell(3);
		push_detent(1'b0, 1'b0);
		wait_drained();

		// Directed, tight bands: each dwell length lands in the next band,
		// ending past all of them with step one.
		load_setting(16'd1, 16'd2, 16'd3, 16'd4, 16'd15, 16'd9, 16'd5, 16'd3);
		for (int d = 0; d <= 4; d++) begin
			push_dwell(d);
			push_detent(d[0], 1'b0);
		end
		push_dwell(2);
		push_detent(1'b1, 1'b1);
		wait_drained();

		// Random phases under several settings and idling patterns.
		for (int ph = 0; ph < 6; ph++) begin
			if (ph < 2) begin
				send_idle_pct = 20;
				recv_idle_pct = 46;
			end else if (ph < 4) begin
				send_idle_pct = 46;
				recv_idle_pct = 20;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (ph)
				0: load_setting(BAND_FASTEST_RST, BAND_FAST_RST, BAND_MEDIUM_RST, BAND_SLOW_RST,
					CFG_DATA_W'(STEP_FASTEST_RST), CFG_DATA_W'(STEP_FAST_RST),
					CFG_DATA_W'(STEP_MEDIUM_RST), CFG_DATA_W'(STEP_SLOW_RST));
				1: load_setting(CFG_DATA_W'($urandom_range(0, 150)),
					CFG_DATA_W'($urandom_range(0, 150)),
					CFG_DATA_W'($urandom_range(0, 150)), CFG_DATA_W'($urandom_range(0, 150)),
					CFG_DATA_W'($urandom_range(1, 15)), CFG_DATA_W'($urandom_range(1, 15)),
					CFG_DATA_W'($urandom_range(1, 15)), CFG_DATA_W'($urandom_range(1, 15)));
				// All bands closed: every detent steps by one; step data above
				// the register width must be masked.
				2: load_setting(16'd0, 16'd0, 16'd0, 16'd0,
					16'hFFFF, 16'hFFF1, 16'h8007, 16'h0010);
				// Zero steps in two bands: detents still register, heading holds.
				3: load_setting(16'd3, 16'd10, 16'd30, 16'd60,
					16'h0010, 16'd15, 16'hABC0, 16'd1);
				// All bands wide open: everything short of saturation is fastest.
				4: load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
					16'd15, 16'd1, 16'd7, 16'd3);
				default: load_setting(CFG_DATA_W'($urandom_range(0, 120)),
					CFG_DATA_W'($urandom_range(0, 120)),
					CFG_DATA_W'($urandom_range(0, 120)), CFG_DATA_W'($urandom_range(0, 120)),
					CFG_DATA_W'($urandom_range(0, 15)), CFG_DATA_W'($urandom_range(0, 15)),
					CFG_DATA_W'($urandom_range(0, 15)), CFG_DATA_W'($urandom_range(0, 15)));
			endcase
			if (ph == 2) begin
				// Pause the sender until every result is back, then resume.
				gen_motion(125);
				wait_drained();
				gen_motion(125);
			end else begin
				gen_motion(250);
			end
			// Fill the queue first so the hold-off backs up the input side.
			if (ph == 0)
				hold_go = 1'b1;
			wait_drained();
		end

		repeat (20) @(negedge clk);
		if (heading_exp_q.size() != 0)
			note_failure($sformatf("%0d expected results never arrived", heading_exp_q.size()));

		$display("Covered %0d pin samples and %0d results over %0d register settings,",
			n_samples, n_results, n_settings);
		$display("both turn directions, every step band, zero steps, wraps and a long output stall.");
		if (n_fail == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d failures", n_fail);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
